@@ rtl/core/nss_pkg.sv @@
package nss_pkg;

    localparam int TOTAL_LINES_DEF        = 264;
    localparam int FIRST_ACTIVE_LINE_DEF  = 30;
    localparam int MAX_BYTES_PER_LINE_DEF = 64;

    localparam logic [8:0] VSYNC_FIRST_LINE = 9'd2;
    localparam logic [8:0] VSYNC_LAST_LINE  = 9'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 48;

    localparam logic [6:0]  BYTES_PER_LINE_RST = 7'd28;
    localparam logic        LINE_DOUBLE_RST    = 1'b1;
    localparam logic [7:0]  ACTIVE_LINES_RST   = 8'd216;
    localparam logic [10:0] HSYNC_WIDTH_RST    = 11'd112;
    localparam logic [10:0] VSYNC_WIDTH_RST    = 11'd1412;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BYTES_PER_LINE = 3'd0,
        CFG_LINE_DOUBLE    = 3'd1,
        CFG_ACTIVE_LINES   = 3'd2,
        CFG_HSYNC_WIDTH    = 3'd3,
        CFG_VSYNC_WIDTH    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic        frame_wrap;
        logic        blank_start;
        logic        blank_end;
        logic [10:0] next_sync_width;
        logic [6:0]  send_bytes;
        logic [13:0] read_offset;
        logic        send_line;
        logic [8:0]  line_number;
    } line_result_t;

endpackage

@@ rtl/core/ntsc_scanline_sequencer_unit.sv @@
// Channel  | Direction | Payload (lowest bit first)
// s_axis   | in        | tdata: restart, zero fill to 8 bits
// m_axis   | out       | tdata: line_number, send_line, read_offset, send_bytes,
//          |           |        next_sync_width, blank_end, blank_start, frame_wrap,
//          |           |        zero fill to 48 bits
// cfg      | in        | cfg_we, cfg_index, cfg_wdata; write-only
//
// Each request goes through an input register, then the line update into the result
// register. One request is accepted per cycle unless the block is stalled by m_axis.
// The input register lets one request be taken while a result waits on m_axis.
// Reset is synchronous on aresetn low and restores the line counter to 1,
// the offset to 0 and all configuration registers to their defaults.
module ntsc_scanline_sequencer_unit #(
    parameter int TOTAL_LINES        = nss_pkg::TOTAL_LINES_DEF,
    parameter int FIRST_ACTIVE_LINE  = nss_pkg::FIRST_ACTIVE_LINE_DEF,
    parameter int MAX_BYTES_PER_LINE = nss_pkg::MAX_BYTES_PER_LINE_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [nss_pkg::IN_DATA_W-1:0]       s_axis_tdata,   // restart
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [nss_pkg::OUT_DATA_W-1:0]      m_axis_tdata,   // line_number, send_line,
                                                                // read_offset, send_bytes,
                                                                // next_sync_width, blank_end,
                                                                // blank_start, frame_wrap
    input  logic                                cfg_we,
    input  logic [nss_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [nss_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import nss_pkg::*;

    localparam logic [8:0] TOTAL_L  = 9'(TOTAL_LINES);
    localparam logic [9:0] FIRST_L  = 10'(FIRST_ACTIVE_LINE);
    localparam logic [8:0] MAX_BPL  = 9'(MAX_BYTES_PER_LINE);

    logic [6:0]   bytes_per_line_reg;
    logic         line_double_reg;
    logic [7:0]   active_lines_reg;
    logic [10:0]  hsync_width_reg;
    logic [10:0]  vsync_width_reg;

    logic         in_valid_reg;
    logic         in_restart_reg;
    logic         out_valid_reg;
    line_result_t out_reg;
    line_result_t out_next;

    logic [8:0]   line_counter_reg;
    logic [8:0]   line_counter_next;
    logic [13:0]  buffer_offset_reg;
    logic [13:0]  buffer_offset_next;

    logic         advance;
    logic         process;
    logic [6:0]   size;
    logic [9:0]   last_active;
    logic         active;
    logic         wrap;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign process       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - $bits(line_result_t))'(0), out_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_per_line_reg <= BYTES_PER_LINE_RST;
            line_double_reg    <= LINE_DOUBLE_RST;
            active_lines_reg   <= ACTIVE_LINES_RST;
            hsync_width_reg    <= HSYNC_WIDTH_RST;
            vsync_width_reg    <= VSYNC_WIDTH_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_BYTES_PER_LINE: bytes_per_line_reg <= cfg_wdata[6:0];
                CFG_LINE_DOUBLE:    line_double_reg    <= cfg_wdata[0];
                CFG_ACTIVE_LINES:   active_lines_reg   <= cfg_wdata[7:0];
                CFG_HSYNC_WIDTH:    hsync_width_reg    <= cfg_wdata;
                CFG_VSYNC_WIDTH:    vsync_width_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        size        = ({2'b00, bytes_per_line_reg} > MAX_BPL) ? MAX_BPL[6:0]
                                                              : bytes_per_line_reg;
        last_active = {2'b00, active_lines_reg} + FIRST_L - 10'd1;
        active      = ({1'b0, line_counter_reg} >= FIRST_L)
                   && ({1'b0, line_counter_reg} <= last_active);
        wrap        = line_counter_reg >= TOTAL_L;

        line_counter_next  = line_counter_reg;
        buffer_offset_next = buffer_offset_reg;
        out_next           = '0;

        if (in_restart_reg) begin
            line_counter_next        = 9'd1;
            buffer_offset_next       = '0;
            out_next.line_number     = 9'd1;
            out_next.next_sync_width = hsync_width_reg;
        end else begin
            out_next.line_number = line_counter_reg;
            out_next.read_offset = buffer_offset_reg;
            out_next.send_line   = active;
            out_next.send_bytes  = active ? size : 7'd0;
            if ((line_counter_reg >= VSYNC_FIRST_LINE)
                    && (line_counter_reg <= VSYNC_LAST_LINE)) begin
                out_next.next_sync_width = vsync_width_reg;
            end else begin
                out_next.next_sync_width = hsync_width_reg;
            end
            out_next.blank_end   = line_counter_reg == VSYNC_LAST_LINE;
            out_next.blank_start = {1'b0, line_counter_reg} == last_active;
            out_next.frame_wrap  = wrap;

            if (active && (!line_double_reg || (line_counter_reg[0] ^ FIRST_L[0]))) begin
                buffer_offset_next = buffer_offset_reg + {7'd0, size};
            end
            if (wrap) begin
                line_counter_next  = 9'd1;
                buffer_offset_next = '0;
            end else begin
                line_counter_next  = line_counter_reg + 9'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            line_counter_reg  <= 9'd1;
            buffer_offset_reg <= '0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (process) begin
                line_counter_reg  <= line_counter_next;
                buffer_offset_reg <= buffer_offset_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_restart_reg <= s_axis_tdata[0];
        end
        if (process) begin
            out_reg <= out_next;
        end
    end

`ifndef ASSERT_OFF
    a_counter_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (line_counter_reg != 9'd0) && (line_counter_reg <= TOTAL_L))
        else $error("line counter left its range");

    a_bytes_only_active: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_reg.send_line |-> out_reg.send_bytes == 7'd0)
        else $error("bytes reported on a line without picture data");

    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        process && in_restart_reg |=> (line_counter_reg == 9'd1)
                                   && (buffer_offset_reg == 14'd0))
        else $error("restart did not clear the counters");

    a_wrap_last_line: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.frame_wrap |-> out_reg.line_number == TOTAL_L)
        else $error("frame wrap reported away from the last line");
`endif

endmodule

@@ verif/tb_ntsc_scanline_sequencer_unit.sv @@
`timescale 1ns / 1ps

module tb_ntsc_scanline_sequencer_unit;
    import nss_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 4;

    logic                   aclk;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   cfg_we        = 1'b0;
    cfg_index_t             cfg_index     = CFG_BYTES_PER_LINE;
    logic [CFG_DATA_W-1:0]  cfg_wdata     = '0;

    logic [6:0]  bytes_per_line_q;
    logic        line_double_q;
    logic [7:0]  active_lines_q;
    logic [10:0] hsync_width_q;
    logic [10:0] vsync_width_q;
    logic [8:0]  line_count;
    logic [13:0] fb_offset;

    line_result_t expected_lines[$];
    bit idle_en        = 1'b1;
    int fail_count     = 0;
    int sent_ticks     = 0;
    int checked_lines  = 0;
    int settings_count = 0;

    ntsc_scanline_sequencer_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic line_result_t advance_scanline(input logic restart);
        line_result_t r;
        int unsigned  cur;
        int unsigned  size;
        int unsigned  last_active;
        r = '0;
        if (restart) begin
            line_count = 9'd1;
            fb_offset = '0;
            r.line_number = 9'd1;
            r.next_sync_width = hsync_width_q;
            return r;
        end
        cur = line_count;
        size = (bytes_per_line_q > MAX_BYTES_PER_LINE_DEF) ? MAX_BYTES_PER_LINE_DEF
                                                            : bytes_per_line_q;
        last_active = active_lines_q + FIRST_ACTIVE_LINE_DEF - 1;
        r.line_number = cur[8:0];
        r.read_offset = fb_offset;
        if (cur >= FIRST_ACTIVE_LINE_DEF && cur <= last_active) begin
            r.send_line = 1'b1;
            r.send_bytes = size[6:0];
            // With line doubling the offset moves on only after the second copy of a row.
            if (!line_double_q || ((cur - FIRST_ACTIVE_LINE_DEF) % 2 == 1)) begin
                fb_offset = fb_offset + size[13:0];
            end
        end
        r.next_sync_width = (cur >= VSYNC_FIRST_LINE && cur <= VSYNC_LAST_LINE) ?
                            vsync_width_q : hsync_width_q;
        r.blank_end = (cur == VSYNC_LAST_LINE);
        r.blank_start = (cur == last_active);
        if (cur + 1 > TOTAL_LINES_DEF) begin
            line_count = 9'd1;
            fb_offset = '0;
            r.frame_wrap = 1'b1;
        end else begin
            line_count = cur[8:0] + 9'd1;
        end
        return r;
    endfunction

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        line_result_t got;
        line_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[$bits(line_result_t)-1:0];
            if (expected_lines.size() == 0) begin
                $error("result with no request outstanding: tdata 0x%0h", m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_lines.pop_front();
                check_field("line_number", want.line_number, got.line_number);
                check_field("send_line", want.send_line, got.send_line);
                check_field("read_offset", want.read_offset, got.read_offset);
                check_field("send_bytes", want.send_bytes, got.send_bytes);
                check_field("next_sync_width", want.next_sync_width, got.next_sync_width);
                check_field("blank_end", want.blank_end, got.blank_end);
                check_field("blank_start", want.blank_start, got.blank_start);
                check_field("frame_wrap", want.frame_wrap, got.frame_wrap);
                checked_lines++;
            end
        end
    end

    initial begin : ready_driver
        forever begin
            @(posedge aclk);
            if (idle_en && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(0, 30)) @(posedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Timed out with %0d results still outstanding.", expected_lines.size());
        $display("FAIL");
        $finish;
    end

    task automatic send_tick(input logic restart);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W-1){1'b0}}, restart};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        expected_lines.push_back(advance_scanline(restart));
        sent_ticks++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_lines.size() != 0);
    endtask

    task automatic put_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // Registers change only with the pipeline empty.
    task automatic program_registers(input logic [6:0] bpl, input logic dbl,
                                     input logic [7:0] act, input logic [10:0] hs,
                                     input logic [10:0] vs);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        put_reg(CFG_BYTES_PER_LINE, CFG_DATA_W'(bpl));
        put_reg(CFG_LINE_DOUBLE, CFG_DATA_W'(dbl));
        put_reg(CFG_ACTIVE_LINES, CFG_DATA_W'(act));
        put_reg(CFG_HSYNC_WIDTH, hs);
        put_reg(CFG_VSYNC_WIDTH, vs);
        cfg_we <= 1'b0;
        bytes_per_line_q = bpl;
        line_double_q = dbl;
        active_lines_q = act;
        hsync_width_q = hs;
        vsync_width_q = vs;
        settings_count++;
    endtask

    task automatic run_ticks(input int count, input bit to_wrap, input int restart_odds);
        int  n;
        bit  wrapped;
        logic restart;
        n = 0;
        wrapped = 1'b0;
        while (n < count || (to_wrap && !wrapped)) begin
            restart = (restart_odds != 0) && ($urandom_range(1, restart_odds) == 1);
            if (!restart && line_count == TOTAL_LINES_DEF) wrapped = 1'b1;
            if (idle_en && $urandom_range(0, 149) == 0) wait_drained();
            send_tick(restart);
            n++;
        end
    endtask

    task automatic test_restart_and_vsync();
        int i;
        send_tick(1'b1);
        send_tick(1'b1);
        for (i = 0; i < 6; i++) send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        wait_drained();
        for (i = 0; i < 4; i++) send_tick(1'b0);
    endtask

    task automatic test_register_extremes();
        program_registers(7'd127, 1'b0, 8'd235, 11'd2047, 11'd0);
        run_ticks(10, 1'b1, 0);
        program_registers(7'd0, 1'b1, 8'd0, 11'd0, 11'd2047);
        send_tick(1'b1);
        run_ticks(40, 1'b0, 0);
        program_registers(7'd65, 1'b0, 8'd1, 11'($urandom_range(0, 2047)),
                          11'($urandom_range(0, 2047)));
        send_tick(1'b1);
        run_ticks(40, 1'b0, 0);
        program_registers(7'd1, 1'b1, 8'd232, 11'd1, 11'd2046);
        run_ticks(10, 1'b1, 0);
        program_registers(7'd64, 1'b1, 8'd255, 11'd1024, 11'd1023);
        send_tick(1'b1);
        run_ticks(50, 1'b0, 0);
    endtask

    task automatic test_random_settings();
        int k;
        for (k = 0; k < 6; k++) begin
            program_registers(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)),
                              11'($urandom_range(0, 2047)));
            run_ticks($urandom_range(20, 50), 1'b0, 100);
        end
    endtask

    task automatic test_steady_stream();
        idle_en = 1'b0;
        program_registers(BYTES_PER_LINE_RST, LINE_DOUBLE_RST, ACTIVE_LINES_RST,
                          HSYNC_WIDTH_RST, VSYNC_WIDTH_RST);
        run_ticks(60, 1'b0, 0);
    endtask

    initial begin : main
        bytes_per_line_q = BYTES_PER_LINE_RST;
        line_double_q = LINE_DOUBLE_RST;
        active_lines_q = ACTIVE_LINES_RST;
        hsync_width_q = HSYNC_WIDTH_RST;
        vsync_width_q = VSYNC_WIDTH_RST;
        line_count = 9'd1;
        fb_offset = '0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_restart_and_vsync();
        test_register_extremes();
        test_random_settings();
        test_steady_stream();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Checked %0d scanline results from %0d ticks over %0d register settings.",
                 checked_lines, sent_ticks, settings_count);
        $display("Covered restarts, frame wraps, sync and blanking lines, size saturation.");
        if (fail_count == 0 && expected_lines.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
